### src/dwc_pkg.sv
// shared types, constants and calendar tables for the date and weekday checker
// no dependencies
package dwc_pkg;

  // field widths
  localparam int unsigned YearW    = 14;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned WeekdayW = 3;

  // shifted year (year + 400, less 1 in january and february) fits in 15 bits
  localparam int unsigned ShYearW  = YearW + 1;
  // year / 4 and shifted year / 4
  localparam int unsigned Y4W      = YearW - 2;
  localparam int unsigned A4W      = ShYearW - 2;

  // floor(x / 25) = (x * 5243) >> 17 for every x below 43690
  localparam int unsigned RecipW     = 13;
  localparam logic [RecipW-1:0] Recip25 = 13'd5243;
  localparam int unsigned RecipShift = 17;
  localparam int unsigned ProdAW     = A4W + RecipW;
  localparam int unsigned ProdYW     = Y4W + RecipW;
  // quotient by 25 of a value below 6400 fits in 8 bits
  localparam int unsigned QuotW      = 8;

  localparam logic [ShYearW-1:0] YearOffset = 15'd400;
  localparam int unsigned        SumW       = 15;
  localparam int unsigned        ShiftDayW  = 6;

  // month, weekday and leap day codes
  localparam logic [MonthW-1:0]   MonthJan = 4'd1;
  localparam logic [MonthW-1:0]   MonthFeb = 4'd2;
  localparam logic [MonthW-1:0]   MonthDec = 4'd12;
  localparam logic [WeekdayW-1:0] WeekdaySat = 3'd6;
  localparam logic [DayW-1:0]     DayLeap    = 5'd29;

  // input word fields
  typedef struct packed {
    logic [WeekdayW-1:0] weekday;
    logic [DayW-1:0]     day;
    logic [MonthW-1:0]   month;
    logic [YearW-1:0]    year;
  } in_word_t;

  // stage one to stage two
  typedef struct packed {
    logic [ShYearW-1:0]   sh_year;
    logic [ProdAW-1:0]    prod_a;
    logic [Y4W-1:0]       year4;
    logic [ProdYW-1:0]    prod_y;
    logic [1:0]           year_lo;
    logic [ShiftDayW-1:0] shift_day;
    logic [WeekdayW-1:0]  weekday;
    logic                 base_ok;
    logic                 len_ok;
    logic                 feb29;
  } s1_t;

  // stage two to stage three
  typedef struct packed {
    logic [SumW-1:0]     sum;
    logic [WeekdayW-1:0] weekday;
    logic                date_ok;
  } s2_t;

  // month length, february as a common year
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // weekday offset of the first of each month for the shifted year
  function automatic logic [WeekdayW-1:0] month_shift(input logic [MonthW-1:0] m);
    logic [WeekdayW-1:0] sh;
    case (m)
      4'd1:    sh = 3'd0;
      4'd2:    sh = 3'd3;
      4'd3:    sh = 3'd2;
      4'd4:    sh = 3'd5;
      4'd5:    sh = 3'd0;
      4'd6:    sh = 3'd3;
      4'd7:    sh = 3'd5;
      4'd8:    sh = 3'd1;
      4'd9:    sh = 3'd4;
      4'd10:   sh = 3'd6;
      4'd11:   sh = 3'd2;
      4'd12:   sh = 3'd4;
      default: sh = 3'd0;
    endcase
    return sh;
  endfunction

endpackage

### src/date_and_weekday_checker.sv
// Gregorian date and weekday checker: one date word in, one verdict word out.
// Three register stages (range checks and /25 products, leap year and weekday
// sum, modulo 7 and compare); a word is taken every cycle while the output is
// not stalled, and its verdict is offered on the output from the third stage
// register. Stall on the output backs up through the stages without losing or
// repeating a word.
// depends on dwc_pkg, dwc_front, dwc_sum, dwc_mod7
module date_and_weekday_checker #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // year_value[13:0], month_value[17:14], day_value[22:18],
  // claimed_weekday[25:23], zero[31:26]
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // accepted[0], zero[7:1]
  output logic [7:0]  m_axis_tdata_o
);

  dwc_pkg::in_word_t word;
  dwc_pkg::s1_t      s1;
  dwc_pkg::s2_t      s2;
  logic v1, r1, v2, r2, accepted;

  // unpack the input word
  assign word.year    = s_axis_tdata_i[13:0];
  assign word.month   = s_axis_tdata_i[17:14];
  assign word.day     = s_axis_tdata_i[22:18];
  assign word.weekday = s_axis_tdata_i[25:23];

  dwc_front #(
    .MAX_YEAR(MAX_YEAR)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .word_i  (word),
    .valid_o (v1),
    .ready_i (r1),
    .stage_o (s1)
  );

  dwc_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (r1),
    .stage_i (s1),
    .valid_o (v2),
    .ready_i (r2),
    .stage_o (s2)
  );

  dwc_mod7 u_mod7 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v2),
    .ready_o    (r2),
    .stage_i    (s2),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .accepted_o (accepted)
  );

  assign m_axis_tdata_o = {7'd0, accepted};

endmodule

### src/dwc_front.sv
// stage one: range checks, shifted year and reciprocal products for /25
// depends on dwc_pkg
module dwc_front #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  dwc_pkg::in_word_t word_i,
  output logic             valid_o,
  input  logic             ready_i,
  output dwc_pkg::s1_t     stage_o
);

  logic         valid_q;
  dwc_pkg::s1_t stage_d, stage_q;
  logic [dwc_pkg::A4W-1:0] a4;
  logic early;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign stage_o = stage_q;

  // january and february count in the previous year
  assign early = (word_i.month <= dwc_pkg::MonthFeb);

  always_comb begin
    stage_d.sh_year = dwc_pkg::ShYearW'(word_i.year) + dwc_pkg::YearOffset
                    - dwc_pkg::ShYearW'(early);
    a4 = stage_d.sh_year[dwc_pkg::ShYearW-1:2];
    stage_d.prod_a = dwc_pkg::ProdAW'(a4) * dwc_pkg::ProdAW'(dwc_pkg::Recip25);
    stage_d.year4 = word_i.year[dwc_pkg::YearW-1:2];
    stage_d.prod_y = dwc_pkg::ProdYW'(stage_d.year4)
                   * dwc_pkg::ProdYW'(dwc_pkg::Recip25);
    stage_d.year_lo = word_i.year[1:0];
    stage_d.shift_day = dwc_pkg::ShiftDayW'(dwc_pkg::month_shift(word_i.month))
                      + dwc_pkg::ShiftDayW'(word_i.day);
    stage_d.weekday = word_i.weekday;
    stage_d.base_ok = (32'(word_i.year) <= MAX_YEAR)
                    && (word_i.month >= dwc_pkg::MonthJan)
                    && (word_i.month <= dwc_pkg::MonthDec)
                    && (word_i.weekday <= dwc_pkg::WeekdaySat)
                    && (word_i.day != '0);
    stage_d.len_ok = (word_i.day <= dwc_pkg::month_len(word_i.month));
    stage_d.feb29 = (word_i.month == dwc_pkg::MonthFeb) && (word_i.day == dwc_pkg::DayLeap);
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q <= stage_d;
    end
  end

endmodule

### src/dwc_sum.sv
// stage two: century quotients, leap year and weekday sum
// depends on dwc_pkg
module dwc_sum (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  dwc_pkg::s1_t stage_i,
  output logic         valid_o,
  input  logic         ready_i,
  output dwc_pkg::s2_t stage_o
);

  logic         valid_q;
  dwc_pkg::s2_t stage_d, stage_q;
  logic [dwc_pkg::QuotW-1:0] q100, qy;
  logic [dwc_pkg::Y4W-1:0]   rem_y;
  logic                      leap;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign stage_o = stage_q;

  always_comb begin
    // shifted year / 100 from (year / 4) / 25
    q100 = dwc_pkg::QuotW'(stage_i.prod_a >> dwc_pkg::RecipShift);
    // year / 4 split into quotient and remainder by 25
    qy = dwc_pkg::QuotW'(stage_i.prod_y >> dwc_pkg::RecipShift);
    rem_y = stage_i.year4 - dwc_pkg::Y4W'(dwc_pkg::Y4W'(qy) * dwc_pkg::Y4W'(25));
    // divisible by 4, and not by 100 unless also by 400
    leap = (stage_i.year_lo == 2'b00) && ((rem_y != '0) || (qy[1:0] == 2'b00));
    stage_d.sum = dwc_pkg::SumW'(stage_i.sh_year)
                + dwc_pkg::SumW'(stage_i.sh_year >> 2)
                - dwc_pkg::SumW'(q100)
                + dwc_pkg::SumW'(q100 >> 2)
                + dwc_pkg::SumW'(stage_i.shift_day);
    stage_d.weekday = stage_i.weekday;
    stage_d.date_ok = stage_i.base_ok && (stage_i.len_ok || (stage_i.feb29 && leap));
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q <= stage_d;
    end
  end

endmodule

### src/dwc_mod7.sv
// stage three: sum modulo 7, weekday compare, output register
// depends on dwc_pkg
module dwc_mod7 (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  dwc_pkg::s2_t stage_i,
  output logic         valid_o,
  input  logic         ready_i,
  output logic         accepted_o
);

  logic       valid_q;
  logic       accepted_d, accepted_q;
  logic [5:0] fold6;
  logic [3:0] fold4;
  logic [2:0] rem7;

  assign ready_o    = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign accepted_o = accepted_q;

  // 8 is 1 mod 7, so octal digits add up to the same residue
  always_comb begin
    fold6 = 6'(stage_i.sum[2:0]) + 6'(stage_i.sum[5:3]) + 6'(stage_i.sum[8:6])
          + 6'(stage_i.sum[11:9]) + 6'(stage_i.sum[14:12]);
    fold4 = 4'(fold6[2:0]) + 4'(fold6[5:3]);
    rem7  = (fold4 >= 4'd7) ? 3'(fold4 - 4'd7) : fold4[2:0];
    accepted_d = stage_i.date_ok && (rem7 == stage_i.weekday);
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      accepted_q <= accepted_d;
    end
  end

endmodule
